// File: src/ddfp_pkg.sv
// Shared constants, types and state encoding for the delimited decimal frame parser.
`default_nettype none

package ddfp_pkg;

   localparam int FIELDS_DEF = 4;
   localparam int DIGITS_DEF = 3;

   localparam int BYTE_W  = 8;
   localparam int VALUE_W = 16;
   localparam int INDEX_W = 2;
   localparam int COUNT_W = 4;

   localparam logic [BYTE_W-1:0]  CH_OPEN   = 8'h23;
   localparam logic [BYTE_W-1:0]  CH_CLOSE  = 8'h24;
   localparam logic [BYTE_W-1:0]  CH_SEP    = 8'h2C;
   localparam logic [BYTE_W-1:0]  CH_ZERO   = 8'h30;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RMW,
      ST_EMIT_RD,
      ST_EMIT_LD
   } seq_state_type;

   // One field handed from the sequencer to the output register.
   typedef struct packed {
      logic               load;
      logic               last;
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] value;
   } emit_type;

endpackage

`default_nettype wire

// File: src/ddfp_req_if.sv
// Input byte channel.
`default_nettype none

interface ddfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source(output valid, output rx_byte, input ready);
   modport sink(input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: src/ddfp_rsp_if.sv
// Result channel carrying one decoded field per transaction.
`default_nettype none

interface ddfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  field_index;
   logic [15:0] field_value;
   logic        last_field;

   modport source(output valid, output field_index, output field_value, output last_field,
                  input ready);
   modport sink(input valid, input field_index, input field_value, input last_field,
                output ready);
endinterface

`default_nettype wire

// File: src/ddfp_csr_if.sv
// Configuration write channel for the ascii_mode register.
`default_nettype none

interface ddfp_csr_if;
   logic valid;
   logic ready;
   logic ascii_mode;

   modport source(output valid, output ascii_mode, input ready);
   modport sink(input valid, input ascii_mode, output ready);
endinterface

`default_nettype wire

// File: src/delimited_decimal_frame_parser_unit.sv
// Top level of the delimited decimal frame parser: configuration register and result register.
//
//  channel  direction  payload                                   transaction when
//  req_if   in         rx_byte[7:0]                              valid && ready
//  rsp_if   out        field_index[1:0] field_value[15:0] last_field  valid && ready
//  csr_if   in         ascii_mode                                valid && ready (always ready)
//
// A digit that is stored is a read-modify-write: the field RAM is read, then the updated
// value is written back. Digits past capacity, delimiters and ignored bytes need no RAM access.
// A closing byte that completes a frame occupies the block while each field in turn gets
// one RAM read and one result load.
// Reset clears frame state and sets ascii_mode to 1; field RAM contents are not cleared.
// A stalled result holds in the output register while further input is taken; readout of
// the next frame waits until that register is free.
`default_nettype none

module delimited_decimal_frame_parser_unit #(
   parameter int FIELDS = ddfp_pkg::FIELDS_DEF,
   parameter int DIGITS = ddfp_pkg::DIGITS_DEF
) (
   input  wire logic      clock,
   input  wire logic      reset,
   ddfp_req_if.sink       req_if,
   ddfp_rsp_if.source     rsp_if,
   ddfp_csr_if.sink       csr_if
);

   logic                              ascii_mode_ff, ascii_mode_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [ddfp_pkg::INDEX_W-1:0]      index_ff, index_in;
   logic [ddfp_pkg::VALUE_W-1:0]      value_ff, value_in;
   logic                              last_ff, last_in;

   logic                              out_free;
   ddfp_pkg::emit_type                emit;

   assign csr_if.ready = 1'b1;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   ddfp_seq #(
      .FIELDS(FIELDS),
      .DIGITS(DIGITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .ascii_mode(ascii_mode_ff),
      .req_valid (req_if.valid),
      .req_byte  (req_if.rx_byte),
      .req_ready (req_if.ready),
      .out_free  (out_free),
      .emit      (emit)
   );

   always_comb begin
      ascii_mode_in = csr_if.valid ? csr_if.ascii_mode : ascii_mode_ff;
      rsp_valid_in  = emit.load || (rsp_valid_ff && !rsp_if.ready);
      index_in      = emit.load ? emit.index : index_ff;
      value_in      = emit.load ? emit.value : value_ff;
      last_in       = emit.load ? emit.last  : last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ascii_mode_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         ascii_mode_ff <= ascii_mode_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      index_ff <= index_in;
      value_ff <= value_in;
      last_ff  <= last_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.field_index = index_ff;
   assign rsp_if.field_value = value_ff;
   assign rsp_if.last_field  = last_ff;

endmodule

`default_nettype wire

// File: src/ddfp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ddfp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/ddfp_seq.sv
// Byte sequencer: frame tracking, read-modify-write of the field RAM and field readout.
`default_nettype none

module ddfp_seq #(
   parameter int FIELDS = ddfp_pkg::FIELDS_DEF,
   parameter int DIGITS = ddfp_pkg::DIGITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          ascii_mode,
   input  wire logic                          req_valid,
   input  wire logic [ddfp_pkg::BYTE_W-1:0]   req_byte,
   output logic                               req_ready,
   input  wire logic                          out_free,
   output ddfp_pkg::emit_type                 emit
);

   localparam int CAPACITY = FIELDS * DIGITS;
   localparam int AW       = (FIELDS > 1) ? $clog2(FIELDS) : 1;
   localparam int PTR_W    = $clog2(FIELDS + 1);
   localparam int POS_W    = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam int TOTAL_W  = $clog2(CAPACITY + 2);

   localparam logic [TOTAL_W-1:0] CAP_T      = TOTAL_W'(CAPACITY);
   localparam logic [POS_W-1:0]   POS_LAST   = POS_W'(DIGITS - 1);
   localparam logic [AW-1:0]      FIELD_LAST = AW'(FIELDS - 1);
   localparam logic [ddfp_pkg::COUNT_W-1:0] DIGITS_C = ddfp_pkg::COUNT_W'(DIGITS);

   ddfp_pkg::seq_state_type state_ff, state_in;

   logic                            in_frame_ff, in_frame_in;
   logic [TOTAL_W-1:0]              total_ff, total_in;
   logic [ddfp_pkg::COUNT_W-1:0]    dif_ff, dif_in;
   logic [PTR_W-1:0]                ptr_ff, ptr_in;
   logic [POS_W-1:0]                pos_ff, pos_in;
   logic [AW-1:0]                   emit_idx_ff, emit_idx_in;

   logic [ddfp_pkg::VALUE_W-1:0]    digit_ff, digit_in;
   logic [AW-1:0]                   addr_ff, addr_in;
   logic                            first_ff, first_in;

   logic                            ram_wr_en;
   logic [ddfp_pkg::VALUE_W-1:0]    ram_wr_data;
   logic                            ram_rd_en;
   logic [AW-1:0]                   ram_rd_addr;
   logic [ddfp_pkg::VALUE_W-1:0]    ram_rd_data;

   logic [ddfp_pkg::VALUE_W-1:0]    byte_ext;
   logic [ddfp_pkg::VALUE_W-1:0]    digit_value;
   logic [ddfp_pkg::VALUE_W-1:0]    base;
   logic [AW+1:0]                   idx_ext;

   assign byte_ext    = {{(ddfp_pkg::VALUE_W - ddfp_pkg::BYTE_W){1'b0}}, req_byte};
   assign digit_value = ascii_mode
      ? byte_ext - {{(ddfp_pkg::VALUE_W - ddfp_pkg::BYTE_W){1'b0}}, ddfp_pkg::CH_ZERO}
      : byte_ext;

   // The first digit of a field starts from zero instead of the stale entry.
   assign base        = first_ff ? '0 : ram_rd_data;
   assign ram_wr_data = (base << 3) + (base << 1) + digit_ff;

   assign idx_ext     = {2'b00, emit_idx_ff};

   ddfp_ram #(
      .WIDTH(ddfp_pkg::VALUE_W),
      .DEPTH(FIELDS)
   ) u_field_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(addr_ff),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ddfp_pkg::ST_IDLE;
         in_frame_ff <= 1'b0;
         total_ff    <= '0;
         dif_ff      <= '0;
         ptr_ff      <= '0;
         pos_ff      <= '0;
         emit_idx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         in_frame_ff <= in_frame_in;
         total_ff    <= total_in;
         dif_ff      <= dif_in;
         ptr_ff      <= ptr_in;
         pos_ff      <= pos_in;
         emit_idx_ff <= emit_idx_in;
      end
      digit_ff <= digit_in;
      addr_ff  <= addr_in;
      first_ff <= first_in;
   end

   always_comb begin
      state_in    = state_ff;
      in_frame_in = in_frame_ff;
      total_in    = total_ff;
      dif_in      = dif_ff;
      ptr_in      = ptr_ff;
      pos_in      = pos_ff;
      emit_idx_in = emit_idx_ff;
      digit_in    = digit_ff;
      addr_in     = addr_ff;
      first_in    = first_ff;

      req_ready   = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = ptr_ff[AW-1:0];
      ram_wr_en   = 1'b0;

      emit.load   = 1'b0;
      emit.last   = (emit_idx_ff == FIELD_LAST);
      emit.index  = idx_ext[ddfp_pkg::INDEX_W-1:0];
      emit.value  = ram_rd_data;

      case (state_ff)
         ddfp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (!in_frame_ff) begin
                  if (req_byte == ddfp_pkg::CH_OPEN) begin
                     in_frame_in = 1'b1;
                     total_in    = '0;
                     dif_in      = '0;
                     ptr_in      = '0;
                     pos_in      = '0;
                  end
               end else if (req_byte == ddfp_pkg::CH_CLOSE) begin
                  if (total_ff == CAP_T) begin
                     in_frame_in = 1'b0;
                     total_in    = '0;
                     dif_in      = '0;
                     ptr_in      = '0;
                     pos_in      = '0;
                     emit_idx_in = '0;
                     state_in    = ddfp_pkg::ST_EMIT_RD;
                  end
               end else if (req_byte == ddfp_pkg::CH_SEP) begin
                  if (dif_ff != DIGITS_C) begin
                     in_frame_in = 1'b0;
                     total_in    = '0;
                     ptr_in      = '0;
                     pos_in      = '0;
                  end
                  dif_in = '0;
               end else begin
                  // Digits past capacity only advance the counters.
                  if (total_ff < CAP_T) begin
                     ram_rd_en = 1'b1;
                     digit_in  = digit_value;
                     addr_in   = ptr_ff[AW-1:0];
                     first_in  = (pos_ff == '0);
                     state_in  = ddfp_pkg::ST_RMW;
                     if (pos_ff == POS_LAST) begin
                        pos_in = '0;
                        ptr_in = ptr_ff + PTR_W'(1);
                     end else begin
                        pos_in = pos_ff + POS_W'(1);
                     end
                  end
                  if (total_ff <= CAP_T) begin
                     total_in = total_ff + TOTAL_W'(1);
                  end
                  if (dif_ff != ddfp_pkg::COUNT_MAX) begin
                     dif_in = dif_ff + ddfp_pkg::COUNT_W'(1);
                  end
               end
            end
         end
         ddfp_pkg::ST_RMW: begin
            ram_wr_en = 1'b1;
            state_in  = ddfp_pkg::ST_IDLE;
         end
         ddfp_pkg::ST_EMIT_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = emit_idx_ff;
            state_in    = ddfp_pkg::ST_EMIT_LD;
         end
         ddfp_pkg::ST_EMIT_LD: begin
            if (out_free) begin
               emit.load = 1'b1;
               if (emit_idx_ff == FIELD_LAST) begin
                  state_in = ddfp_pkg::ST_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff + AW'(1);
                  state_in    = ddfp_pkg::ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = ddfp_pkg::ST_IDLE;
         end
      endcase
   end

   // A write-back always follows a read of the same entry in the cycle before.
   assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> $past(ram_rd_en) && ($past(ram_rd_addr) == addr_ff))
      else $error("field RAM write without matching read");

   assert property (@(posedge clock) disable iff (reset)
      int'(total_ff) <= CAPACITY + 1)
      else $error("digit count exceeded its saturation value");

   // Field pointer and digit position track the running digit count.
   assert property (@(posedge clock) disable iff (reset)
      (int'(total_ff) <= CAPACITY) |->
         (int'(ptr_ff) * DIGITS + int'(pos_ff) == int'(total_ff)))
      else $error("field pointer out of step with digit count");

   assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> (total_ff == '0) && (dif_ff == '0))
      else $error("counters not cleared outside a frame");

   assert property (@(posedge clock) disable iff (reset)
      (emit.load && emit.last) |=> (state_ff == ddfp_pkg::ST_IDLE))
      else $error("sequencer did not return to idle after the last field");

endmodule

`default_nettype wire

// File: dv/delimited_decimal_frame_parser_unit_tb.sv
// Self-checking testbench for the delimited decimal frame parser: directed table, then random frames.
module delimited_decimal_frame_parser_unit_tb;

   localparam int FIELDS        = ddfp_pkg::FIELDS_DEF;
   localparam int DIGITS        = ddfp_pkg::DIGITS_DEF;
   localparam int CAPACITY      = FIELDS * DIGITS;
   localparam int SETTLE_CYCLES = 2 * FIELDS + 12;
   localparam int PHASE_ITEMS   = 80;
   localparam int DIR_ROWS      = 26;
   localparam int SIDE_REQ      = 0;
   localparam int SIDE_RSP      = 1;

   typedef struct packed {
      logic [ddfp_pkg::INDEX_W-1:0] index;
      logic [ddfp_pkg::VALUE_W-1:0] value;
      logic                         last;
   } field_result_type;

   typedef struct packed {
      logic [ddfp_pkg::BYTE_W-1:0]              rx;
      logic                                     typed;
      logic [FIELDS-1:0][ddfp_pkg::VALUE_W-1:0] vals;
   } stim_row_type;

   localparam logic [FIELDS-1:0][ddfp_pkg::VALUE_W-1:0] NO_VALS = '0;

   // Rows with typed values carry the whole frame readout, field 0 in the low slot.
   stim_row_type dir_table [DIR_ROWS] = '{
      '{"A",                1'b0, NO_VALS},
      '{ddfp_pkg::CH_CLOSE, 1'b0, NO_VALS},
      '{ddfp_pkg::CH_OPEN,  1'b0, NO_VALS},
      '{"0",                1'b0, NO_VALS},
      '{"0",                1'b0, NO_VALS},
      '{"0",                1'b0, NO_VALS},
      '{ddfp_pkg::CH_SEP,   1'b0, NO_VALS},
      '{"9",                1'b0, NO_VALS},
      '{"9",                1'b0, NO_VALS},
      '{"9",                1'b0, NO_VALS},
      '{ddfp_pkg::CH_CLOSE, 1'b0, NO_VALS},
      '{"9",                1'b0, NO_VALS},
      '{"9",                1'b0, NO_VALS},
      '{"9",                1'b0, NO_VALS},
      '{"9",                1'b0, NO_VALS},
      '{"9",                1'b0, NO_VALS},
      '{"9",                1'b0, NO_VALS},
      '{ddfp_pkg::CH_CLOSE, 1'b1, {16'd999, 16'd999, 16'd999, 16'd0}},
      '{ddfp_pkg::CH_OPEN,  1'b0, NO_VALS},
      '{8'hFF,              1'b0, NO_VALS},
      '{8'h00,              1'b0, NO_VALS},
      '{ddfp_pkg::CH_OPEN,  1'b0, NO_VALS},
      '{ddfp_pkg::CH_SEP,   1'b0, NO_VALS},
      '{"1",                1'b0, NO_VALS},
      '{ddfp_pkg::CH_SEP,   1'b0, NO_VALS},
      '{"5",                1'b0, NO_VALS}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   ddfp_req_if req_if();
   ddfp_rsp_if rsp_if();
   ddfp_csr_if csr_if();

   delimited_decimal_frame_parser_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Parser state as the testbench tracks it.
   logic                         mode_ascii;
   logic                         in_frame_p;
   int                           digits_seen;
   logic [ddfp_pkg::COUNT_W-1:0] field_digits;
   logic [ddfp_pkg::VALUE_W-1:0] field_acc [FIELDS];

   field_result_type field_expect_q [$];
   field_result_type frame_readout [FIELDS];
   field_result_type rsp_seen;
   field_result_type rsp_want;

   int mismatch_count = 0;
   int sent_items     = 0;
   int quiet_left [2] = '{0, 0};
   int rsp_hold       = 0;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $time, what);
   endtask

   // Wait states between transactions, with occasional stretches of back-to-back traffic.
   function automatic int draw_wait(input int side);
      if (quiet_left[side] > 0) begin
         quiet_left[side]--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         quiet_left[side] = $urandom_range(8, 30);
         return 0;
      end
      return $urandom_range(0, 9);
   endfunction

   function automatic void clear_frame();
      in_frame_p   = 1'b0;
      digits_seen  = 0;
      field_digits = '0;
   endfunction

   // Applies one byte to the tracked state; returns how many fields it reads out.
   function automatic int decode_byte(input logic [ddfp_pkg::BYTE_W-1:0] b);
      logic [ddfp_pkg::VALUE_W-1:0] digit;
      logic [ddfp_pkg::VALUE_W-1:0] base;
      int                           f;
      if (!in_frame_p) begin
         if (b == ddfp_pkg::CH_OPEN) begin
            clear_frame();
            in_frame_p = 1'b1;
         end
         return 0;
      end
      if (b == ddfp_pkg::CH_CLOSE) begin
         if (digits_seen == CAPACITY) begin
            for (int i = 0; i < FIELDS; i++) begin
               frame_readout[i] = '{index: ddfp_pkg::INDEX_W'(i), value: field_acc[i],
                                    last: 1'(i == FIELDS - 1)};
            end
            clear_frame();
            return FIELDS;
         end
      end else if (b == ddfp_pkg::CH_SEP) begin
         if (field_digits != DIGITS) begin
            clear_frame();
         end
         field_digits = '0;
      end else begin
         digit = mode_ascii
            ? ddfp_pkg::VALUE_W'(b) - ddfp_pkg::VALUE_W'(ddfp_pkg::CH_ZERO)
            : ddfp_pkg::VALUE_W'(b);
         if (digits_seen < CAPACITY) begin
            f = digits_seen / DIGITS;
            base = (digits_seen % DIGITS == 0) ? '0 : field_acc[f];
            field_acc[f] = ddfp_pkg::VALUE_W'(base * 10 + digit);
         end
         if (digits_seen <= CAPACITY) begin
            digits_seen++;
         end
         if (field_digits < ddfp_pkg::COUNT_MAX) begin
            field_digits++;
         end
      end
      return 0;
   endfunction

   // Returns at the clock edge where the byte is taken.
   task automatic send_byte(input logic [ddfp_pkg::BYTE_W-1:0] b);
      int gap;
      gap = draw_wait(SIDE_REQ);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.rx_byte <= b;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_and_predict(input logic [ddfp_pkg::BYTE_W-1:0] b);
      int n;
      sent_items++;
      send_byte(b);
      n = decode_byte(b);
      for (int i = 0; i < n; i++) begin
         field_expect_q.push_back(frame_readout[i]);
      end
   endtask

   function automatic logic [ddfp_pkg::BYTE_W-1:0] pick_digit();
      logic [ddfp_pkg::BYTE_W-1:0] b;
      if (mode_ascii && $urandom_range(0, 9) != 0) begin
         return ddfp_pkg::CH_ZERO + ddfp_pkg::BYTE_W'($urandom_range(0, 9));
      end
      do b = ddfp_pkg::BYTE_W'($urandom_range(0, 255));
      while (b == ddfp_pkg::CH_CLOSE || b == ddfp_pkg::CH_SEP);
      return b;
   endfunction

   task automatic run_traffic(input int target);
      int kind;
      int pick;
      sent_items = 0;
      while (sent_items < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            // Two separators always leave the frame closed, whatever the field count was.
            if (in_frame_p) begin
               send_and_predict(ddfp_pkg::CH_SEP);
               send_and_predict(ddfp_pkg::CH_SEP);
            end
            send_and_predict(ddfp_pkg::CH_OPEN);
            for (int f = 0; f < FIELDS; f++) begin
               for (int k = 0; k < DIGITS; k++) begin
                  send_and_predict(pick_digit());
               end
               if (f < FIELDS - 1 ? $urandom_range(0, 3) != 0 : $urandom_range(0, 7) == 0) begin
                  send_and_predict(ddfp_pkg::CH_SEP);
               end
            end
            send_and_predict(ddfp_pkg::CH_CLOSE);
         end else if (kind < 75) begin
            repeat ($urandom_range(1, 10)) begin
               pick = $urandom_range(0, 19);
               if (pick < 14) begin
                  send_and_predict(pick_digit());
               end else if (pick < 17) begin
                  send_and_predict(ddfp_pkg::CH_SEP);
               end else begin
                  send_and_predict(ddfp_pkg::CH_CLOSE);
               end
            end
         end else if (kind < 85) begin
            // Overlong frame: the close is ignored and the separator aborts it.
            send_and_predict(ddfp_pkg::CH_OPEN);
            repeat ($urandom_range(CAPACITY + 1, CAPACITY + 8)) begin
               send_and_predict(pick_digit());
            end
            send_and_predict(ddfp_pkg::CH_CLOSE);
            send_and_predict(ddfp_pkg::CH_SEP);
         end else begin
            repeat ($urandom_range(1, 6)) begin
               send_and_predict(ddfp_pkg::BYTE_W'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   task automatic quiesce();
      req_if.valid <= 1'b0;
      while (field_expect_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(input logic ascii);
      csr_if.valid      <= 1'b1;
      csr_if.ascii_mode <= ascii;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      mode_ascii = ascii;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         rsp_seen = '{index: rsp_if.field_index, value: rsp_if.field_value,
                      last: rsp_if.last_field};
         if (field_expect_q.size() == 0) begin
            report_mismatch($sformatf("unexpected field index %0d value %0d last %0b",
                                      rsp_seen.index, rsp_seen.value, rsp_seen.last));
         end else begin
            rsp_want = field_expect_q.pop_front();
            if (rsp_seen.index != rsp_want.index || rsp_seen.value != rsp_want.value ||
                rsp_seen.last != rsp_want.last) begin
               report_mismatch($sformatf(
                  "field got index %0d value %0d last %0b, want index %0d value %0d last %0b",
                  rsp_seen.index, rsp_seen.value, rsp_seen.last,
                  rsp_want.index, rsp_want.value, rsp_want.last));
            end
         end
         rsp_hold = draw_wait(SIDE_RSP);
         rsp_if.ready <= (rsp_hold == 0);
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         if (rsp_hold == 0) begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   initial begin
      int n;
      req_if.valid      = 1'b0;
      req_if.rx_byte    = '0;
      csr_if.valid      = 1'b0;
      csr_if.ascii_mode = 1'b0;
      rsp_if.ready      = 1'b1;
      mode_ascii        = 1'b1;
      clear_frame();
      for (int i = 0; i < FIELDS; i++) begin
         field_acc[i] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIR_ROWS; r++) begin
         send_byte(dir_table[r].rx);
         n = decode_byte(dir_table[r].rx);
         for (int i = 0; i < n; i++) begin
            if (dir_table[r].typed) begin
               field_expect_q.push_back('{index: ddfp_pkg::INDEX_W'(i),
                                          value: dir_table[r].vals[i],
                                          last: 1'(i == FIELDS - 1)});
            end else begin
               field_expect_q.push_back(frame_readout[i]);
            end
         end
      end
      run_traffic(PHASE_ITEMS);

      quiesce();
      write_mode(1'b0);
      run_traffic(PHASE_ITEMS);
      quiesce();
      write_mode(1'b1);
      run_traffic(PHASE_ITEMS);
      quiesce();
      write_mode(1'b0);
      run_traffic(PHASE_ITEMS);
      quiesce();

      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

// File: files.f
src/ddfp_pkg.sv
src/ddfp_req_if.sv
src/ddfp_rsp_if.sv
src/ddfp_csr_if.sv
src/ddfp_ram.sv
src/ddfp_seq.sv
src/delimited_decimal_frame_parser_unit.sv
dv/delimited_decimal_frame_parser_unit_tb.sv
